// File: rtl/nss_pkg.sv
// Shared constants, codes and types for the NFA state-set stepper.
package nss_pkg;

  // Automaton size.
  localparam int NumStates  = 16;
  localparam int NumSymbols = 4;

  // Field widths.
  localparam int OpW    = 2;
  localparam int StateW = 4;
  localparam int SymW   = 2;
  localparam int SetW   = 16;

  // Transition table geometry.
  localparam int Rows  = NumStates * NumSymbols;
  localparam int RowAw = (Rows > 1) ? $clog2(Rows) : 1;

  // States visited by a step: only the ones a 16-bit set can hold.
  localparam int IterStates = (NumStates < SetW) ? NumStates : SetW;
  localparam int CntW       = (IterStates > 1) ? $clog2(IterStates) : 1;

  localparam logic [SetW-1:0] StateMask =
    (NumStates >= SetW) ? {SetW{1'b1}} : SetW'((1 << NumStates) - 1);

  // Configuration port.
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam logic CfgInitial = 1'b0;
  localparam logic CfgFinal   = 1'b1;

  typedef enum logic [OpW-1:0] {
    OpAdd   = 2'd0,
    OpStart = 2'd1,
    OpStep  = 2'd2
  } op_e;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [StateW-1:0] from_state;
    logic [SymW-1:0]   symbol;
    logic [StateW-1:0] to_state;
  } item_t;

  typedef struct packed {
    logic [SetW-1:0] current_set;
    logic            holds_final;
    logic            set_empty;
  } result_t;

  // Controller -> datapath.
  typedef struct packed {
    logic load;     // latch the accepted item, clear step state
    logic add_rd;   // read the row an add touches
    logic add_wr;   // write back the row with the new bit
    logic step_rd;  // read the row of the counted state
    logic commit;   // update the active set and load the result
  } cmd_t;

  // Datapath -> controller.
  typedef struct packed {
    logic op_add;
    logic op_step;
    logic cnt_last;
    logic out_free;
  } sts_t;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StDecode = 5'b00010,
    StAddWr  = 5'b00100,
    StStep   = 5'b01000,
    StDone   = 5'b10000
  } state_e;

  function automatic logic [RowAw-1:0] row_addr(input logic [StateW-1:0] state,
                                                input logic [SymW-1:0] sym);
    row_addr = RowAw'(int'(state) * NumSymbols + int'(sym));
  endfunction

endpackage

// File: rtl/nss_if.sv
// Stream interfaces for input items and result items.
interface nss_item_if;
  logic                          valid;
  logic                          ready;
  logic [nss_pkg::OpW-1:0]       op;
  logic [nss_pkg::StateW-1:0]    from_state;
  logic [nss_pkg::SymW-1:0]      symbol;
  logic [nss_pkg::StateW-1:0]    to_state;

  modport source (output valid, op, from_state, symbol, to_state, input ready);
  modport sink   (input valid, op, from_state, symbol, to_state, output ready);
endinterface

interface nss_result_if;
  logic                        valid;
  logic                        ready;
  logic [nss_pkg::SetW-1:0]    current_set;
  logic                        holds_final;
  logic                        set_empty;

  modport source (output valid, current_set, holds_final, set_empty, input ready);
  modport sink   (input valid, current_set, holds_final, set_empty, output ready);
endinterface

// File: rtl/nss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nss_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/nss_ctrl.sv
// Controller state machine sequencing add, start and step items.
module nss_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  nss_pkg::sts_t  sts_i,
  output nss_pkg::cmd_t  cmd_o
);

  nss_pkg::state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      nss_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = nss_pkg::StDecode;
        end
      end
      nss_pkg::StDecode: begin
        if (sts_i.op_add) begin
          cmd_o.add_rd = 1'b1;
          state_d      = nss_pkg::StAddWr;
        end else if (sts_i.op_step) begin
          state_d = nss_pkg::StStep;
        end else begin
          state_d = nss_pkg::StDone;
        end
      end
      nss_pkg::StAddWr: begin
        cmd_o.add_wr = 1'b1;
        state_d      = nss_pkg::StDone;
      end
      nss_pkg::StStep: begin
        cmd_o.step_rd = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = nss_pkg::StDone;
        end
      end
      nss_pkg::StDone: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = nss_pkg::StIdle;
        end
      end
      default: begin
        state_d = nss_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nss_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/nss_datapath.sv
// Datapath: item latch, transition table, step accumulator, active set, result register.
module nss_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nss_pkg::item_t              item_i,
  input  logic [nss_pkg::SetW-1:0]    initial_mask_i,
  input  logic [nss_pkg::SetW-1:0]    final_mask_i,
  input  nss_pkg::cmd_t               cmd_i,
  output nss_pkg::sts_t               sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output nss_pkg::result_t            result_o
);

  nss_pkg::item_t               item_q;
  logic [nss_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [nss_pkg::Rows-1:0]     valid_q, valid_d;
  logic                         hit_q, hit_d;
  logic [nss_pkg::SetW-1:0]     acc_q, acc_next;
  logic [nss_pkg::SetW-1:0]     active_q, active_d;
  logic                         out_valid_q, out_valid_d;
  nss_pkg::result_t             res_q;

  logic [nss_pkg::RowAw-1:0]    add_addr, step_addr;
  logic [nss_pkg::StateW-1:0]   step_state;
  logic                         sym_ok, add_ok;
  logic                         add_row_valid, step_row_valid;
  logic [nss_pkg::SetW-1:0]     rdata, wdata;
  logic                         ram_we, ram_re;
  logic [nss_pkg::RowAw-1:0]    ram_raddr;
  logic [nss_pkg::SetW-1:0]     new_set;

  assign sym_ok = int'(item_q.symbol) < nss_pkg::NumSymbols;
  assign add_ok = sym_ok && (int'(item_q.from_state) < nss_pkg::NumStates)
                         && (int'(item_q.to_state) < nss_pkg::NumStates);

  assign step_state = nss_pkg::StateW'(cnt_q);
  assign add_addr   = nss_pkg::row_addr(item_q.from_state, item_q.symbol);
  assign step_addr  = nss_pkg::row_addr(step_state, item_q.symbol);

  // Rows never written read as zero.
  assign add_row_valid  = add_ok && valid_q[add_addr];
  assign step_row_valid = sym_ok && valid_q[step_addr];

  assign ram_we    = cmd_i.add_wr && add_ok;
  assign ram_re    = cmd_i.add_rd || cmd_i.step_rd;
  assign ram_raddr = cmd_i.step_rd ? step_addr : add_addr;
  assign wdata     = (add_row_valid ? rdata : '0)
                   | (nss_pkg::SetW'(1) << item_q.to_state);

  nss_ram #(
    .Width (nss_pkg::SetW),
    .Depth (nss_pkg::Rows)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (add_addr),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  assign hit_d    = cmd_i.step_rd && active_q[cnt_q] && step_row_valid;
  assign acc_next = acc_q | (hit_q ? rdata : '0);

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      cnt_d = '0;
    end else if (cmd_i.step_rd) begin
      cnt_d = cnt_q + nss_pkg::CntW'(1);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (ram_we) begin
      valid_d[add_addr] = 1'b1;
    end
  end

  always_comb begin
    case (item_q.op)
      nss_pkg::OpStart: new_set = initial_mask_i & nss_pkg::StateMask;
      nss_pkg::OpStep:  new_set = sym_ok ? (acc_next & nss_pkg::StateMask) : '0;
      default:          new_set = active_q;
    endcase
  end

  assign active_d    = cmd_i.commit ? new_set : active_q;
  assign out_valid_d = cmd_i.commit ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      valid_q     <= '0;
      hit_q       <= 1'b0;
      acc_q       <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      hit_q       <= hit_d;
      acc_q       <= cmd_i.load ? '0 : acc_next;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.commit) begin
      res_q.current_set <= new_set;
      res_q.holds_final <= |(new_set & final_mask_i);
      res_q.set_empty   <= ~|new_set;
    end
  end

  assign sts_o.op_add   = item_q.op == nss_pkg::OpAdd;
  assign sts_o.op_step  = item_q.op == nss_pkg::OpStep;
  assign sts_o.cnt_last = int'(cnt_q) == nss_pkg::IterStates - 1;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

// File: rtl/nfa_state_set_stepper.sv
// NFA state-set stepper: top level with configuration registers and APB write/read port.
// Per transaction: a start or unused op goes from decode to commit, an add reads and
// then writes back its table row, and a step reads one table row per state.
// Throughput: one item in flight; the next is taken once the result is committed.
// Reset (async, active low) clears the active set, both masks and the per-row valid
// bits, so the whole transition table reads as zero right after reset.
module nfa_state_set_stepper (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nss_pkg::CfgAddrW-1:0]   paddr,
  input  logic [nss_pkg::CfgDataW-1:0]   pwdata,
  output logic [nss_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready,
  nss_item_if.sink                       in_i,
  nss_result_if.source                   out_o
);

  // Configuration registers: initial_mask at 0x0, final_mask at 0x4.
  // The user must write these only while the block is idle; the block does not enforce it, and there is no shadowing.
  logic [nss_pkg::SetW-1:0] initial_mask_q, initial_mask_d;
  logic [nss_pkg::SetW-1:0] final_mask_q, final_mask_d;
  logic                     cfg_wr;
  logic                     cfg_idx;
  logic [nss_pkg::SetW-1:0] rd_mask;

  nss_pkg::item_t   item;
  nss_pkg::result_t result;
  nss_pkg::cmd_t    cmd;
  nss_pkg::sts_t    sts;
  logic             in_ready;
  logic             out_valid;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[nss_pkg::CfgAddrW-1];

  always_comb begin
    initial_mask_d = initial_mask_q;
    final_mask_d   = final_mask_q;
    if (cfg_wr) begin
      case (cfg_idx)
        nss_pkg::CfgInitial: initial_mask_d = pwdata[nss_pkg::SetW-1:0];
        nss_pkg::CfgFinal:   final_mask_d   = pwdata[nss_pkg::SetW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      nss_pkg::CfgInitial: rd_mask = initial_mask_q;
      nss_pkg::CfgFinal:   rd_mask = final_mask_q;
      default:             rd_mask = '0;
    endcase
  end

  assign prdata = nss_pkg::CfgDataW'(rd_mask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_mask_q <= '0;
      final_mask_q   <= '0;
    end else begin
      initial_mask_q <= initial_mask_d;
      final_mask_q   <= final_mask_d;
    end
  end

  // Input transaction payload, latched by the datapath on accept.
  assign item.op         = in_i.op;
  assign item.from_state = in_i.from_state;
  assign item.symbol     = in_i.symbol;
  assign item.to_state   = in_i.to_state;
  assign in_i.ready      = in_ready;

  // Sequencer: idle -> decode -> (add read/write | per-state step scan) -> commit.
  nss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table RAM, step accumulator and output register; the output register lets
  // a new transaction be accepted while the previous result is still pending.
  nss_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item),
    .initial_mask_i (initial_mask_q),
    .final_mask_i   (final_mask_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_valid),
    .result_o       (result)
  );

  assign out_o.valid       = out_valid;
  assign out_o.current_set = result.current_set;
  assign out_o.holds_final = result.holds_final;
  assign out_o.set_empty   = result.set_empty;

endmodule

// File: tb/nfa_state_set_stepper_tb.sv
// Self-checking testbench for the NFA state-set stepper: predictor, scoreboard, bus drivers.
`timescale 1ns / 1ps

module nfa_state_set_stepper_tb;
  import nss_pkg::*;

  // Op code 3 is left unused by the block: no state change, result echoes the set.
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  localparam int NumPhases     = 12;
  localparam int PhaseItems    = 155;  // counted transactions per random phase
  localparam int PhaseAdds     = 20;   // keeps the table sparse so sets stay varied
  localparam int SettleCycles  = 4;    // block finishes its commit before a config write
  localparam int TailCycles    = 25;   // longer than a step's latency
  localparam int StallLimit    = 2000; // cycles with no transaction at all

  // Scoreboard: tracks the automaton state and queues the expected result per item.
  class state_set_scoreboard;
    logic [SetW-1:0] row_bits [Rows];  // next-state mask per (state, symbol)
    logic [SetW-1:0] active_set;
    logic [SetW-1:0] initial_mask;
    logic [SetW-1:0] final_mask;
    result_t         pending_results [$];
    int              mismatches;
    int              results_checked;
    int              empty_results;
    int              final_results;
    int              op_counts [4];

    function void clear();
      foreach (row_bits[i]) row_bits[i] = '0;
      active_set   = '0;
      initial_mask = '0;
      final_mask   = '0;
      mismatches      = 0;
      results_checked = 0;
      empty_results   = 0;
      final_results   = 0;
      foreach (op_counts[i]) op_counts[i] = 0;
    endfunction

    // Apply one accepted input transaction and queue the result it must produce.
    function void note_item(item_t it);
      result_t         exp_res;
      logic [SetW-1:0] acc;
      op_counts[it.op]++;
      if (it.op == OpAdd) begin
        if (int'(it.from_state) < NumStates && int'(it.to_state) < NumStates &&
            int'(it.symbol) < NumSymbols && int'(it.to_state) < SetW)
          row_bits[int'(it.from_state) * NumSymbols + int'(it.symbol)][it.to_state] = 1'b1;
      end else if (it.op == OpStart) begin
        active_set = initial_mask & StateMask;
      end else if (it.op == OpStep) begin
        // Union of the rows for this symbol over every active state.
        acc = '0;
        if (int'(it.symbol) < NumSymbols) begin
          for (int s = 0; s < NumStates && s < SetW; s++)
            if (active_set[s]) acc |= row_bits[s * NumSymbols + int'(it.symbol)];
        end
        active_set = acc & StateMask;
      end
      exp_res.current_set = active_set;
      exp_res.holds_final = |(active_set & final_mask);
      exp_res.set_empty   = (active_set == '0);
      pending_results.push_back(exp_res);
    endfunction

    function void check_result(result_t got);
      result_t exp_res;
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with nothing expected: set=%h final=%b empty=%b",
                   $time, got.current_set, got.holds_final, got.set_empty);
        return;
      end
      exp_res = pending_results.pop_front();
      if (got.current_set !== exp_res.current_set ||
          got.holds_final !== exp_res.holds_final ||
          got.set_empty !== exp_res.set_empty) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] result mismatch: expected set=%h final=%b empty=%b, ",
                    "got set=%h final=%b empty=%b"},
                   $time, exp_res.current_set, exp_res.holds_final, exp_res.set_empty,
                   got.current_set, got.holds_final, got.set_empty);
      end
      if (exp_res.set_empty) empty_results++;
      if (exp_res.holds_final) final_results++;
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  nss_item_if   item_bus ();
  nss_result_if result_bus ();

  state_set_scoreboard sb;

  // Idle control, switched per phase to get stretches without gaps or stalls.
  bit tx_no_gaps;
  bit rx_no_stalls;
  int counted_items;  // transactions that the block acts on (unused op excluded)
  int cfg_writes;
  int idle_cycles;

  nfa_state_set_stepper DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_i   (item_bus),
    .out_o  (result_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: any transaction on either stream or the config port resets the count.
  always @(posedge clk_i) begin
    if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
        (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no transaction for %0d cycles", StallLimit);
      $display("status: fail");
      $finish;
    end
  end

  // All drive tasks enter and leave right after a falling edge.
  task automatic send_item(input logic [OpW-1:0] op, input logic [StateW-1:0] from_s,
                           input logic [SymW-1:0] sym, input logic [StateW-1:0] to_s);
    item_t it;
    int    gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      item_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    // valid stays high across back-to-back transactions
    item_bus.valid      = 1'b1;
    item_bus.op         = op;
    item_bus.from_state = from_s;
    item_bus.symbol     = sym;
    item_bus.to_state   = to_s;
    do @(posedge clk_i); while (!item_bus.ready);
    it.op         = op;
    it.from_state = from_s;
    it.symbol     = sym;
    it.to_state   = to_s;
    sb.note_item(it);
    if (op != OpUnused) counted_items++;
    @(negedge clk_i);
  endtask

  // Don't-care fields are still randomized so every input bit toggles.
  task automatic send_random(input logic [OpW-1:0] op);
    send_item(op, StateW'($urandom_range(0, 15)), SymW'($urandom_range(0, 3)),
              StateW'($urandom_range(0, 15)));
  endtask

  // Hold the sender off until every expected result is back.
  task automatic wait_drained(input bit settle);
    item_bus.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    if (settle) repeat (SettleCycles) @(negedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle; upper data bits are junk on purpose.
  task automatic write_mask(input logic reg_idx, input logic [SetW-1:0] value);
    paddr   = CfgAddrW'(4 * int'(reg_idx));
    pwdata  = {16'($urandom), value};
    pwrite  = 1'b1;
    psel    = 1'b1;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_idx == CfgInitial) sb.initial_mask = value;
    else sb.final_mask = value;
    cfg_writes++;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function automatic logic [SetW-1:0] sparse_mask();
    logic [SetW-1:0] m;
    m = '0;
    repeat ($urandom_range(1, 3)) m[$urandom_range(0, SetW - 1)] = 1'b1;
    return m;
  endfunction

  // Mostly well-formed words (start, then steps), some table adds, a little noise.
  task automatic run_phase(input int quota, input int add_budget);
    int first;
    int pick;
    int adds_left;
    first     = counted_items;
    adds_left = add_budget;
    while (counted_items - first < quota) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 39) == 0) wait_drained(1'b0);
      if (pick < 15 && adds_left > 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_random(OpAdd);
          adds_left--;
        end
      end else if (pick < 85) begin
        send_random(OpStart);
        repeat ($urandom_range(1, 6)) send_random(OpStep);
      end else if (pick < 90) begin
        // long word: lets the set settle into a fixed point or die out
        send_random(OpStart);
        repeat ($urandom_range(10, 20)) send_random(OpStep);
      end else begin
        case ($urandom_range(0, 2))
          0: send_random(OpUnused);
          1: send_random(OpStep);
          default: send_random(OpStart);
        endcase
      end
    end
  endtask

  // Result side: random stall per transaction, ready held otherwise.
  initial begin : result_sink
    result_t got;
    int      stall;
    result_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = rx_no_stalls ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        result_bus.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_bus.ready = 1'b1;
      do @(posedge clk_i); while (!result_bus.valid);
      got.current_set = result_bus.current_set;
      got.holds_final = result_bus.holds_final;
      got.set_empty   = result_bus.set_empty;
      sb.check_result(got);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int leftover;
    sb = new;
    sb.clear();
    counted_items = 0;
    cfg_writes    = 0;
    idle_cycles   = 0;
    tx_no_gaps    = 1'b0;
    rx_no_stalls  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    item_bus.valid      = 1'b0;
    item_bus.op         = '0;
    item_bus.from_state = '0;
    item_bus.symbol     = '0;
    item_bus.to_state   = '0;
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // --- Directed part ---
    // Masks at reset value: step and unused op on the empty set, start from a zero mask.
    send_item(OpStep, 4'd3, 2'd0, 4'd9);
    send_item(OpUnused, 4'd15, 2'd3, 4'd15);
    send_item(OpStart, 4'd0, 2'd0, 4'd0);
    // State/symbol extremes, plus a repeat of an existing transition.
    send_item(OpAdd, 4'd0, 2'd0, 4'd15);
    send_item(OpAdd, 4'd15, 2'd3, 4'd0);
    send_item(OpAdd, 4'd0, 2'd0, 4'd15);
    send_item(OpAdd, 4'd5, 2'd1, 4'd10);
    send_item(OpAdd, 4'd10, 2'd2, 4'd5);
    wait_drained(1'b1);

    // All states initial and final.
    write_mask(CfgInitial, 16'hFFFF);
    write_mask(CfgFinal, 16'hFFFF);
    send_item(OpStart, 4'd7, 2'd1, 4'd7);
    send_item(OpStep, 4'd0, 2'd0, 4'd0);
    send_item(OpStep, 4'd0, 2'd3, 4'd0);
    send_item(OpStep, 4'd0, 2'd1, 4'd0);
    send_item(OpUnused, 4'd0, 2'd0, 4'd0);
    wait_drained(1'b1);

    // Single initial state, no final states: walk 0 -> 15 -> 0 -> 15, then die out.
    write_mask(CfgInitial, 16'h0001);
    write_mask(CfgFinal, 16'h0000);
    send_item(OpStart, 4'd0, 2'd0, 4'd0);
    send_item(OpStep, 4'd0, 2'd0, 4'd0);
    send_item(OpStep, 4'd0, 2'd3, 4'd0);
    send_item(OpStep, 4'd0, 2'd0, 4'd0);
    send_item(OpStep, 4'd0, 2'd1, 4'd0);
    send_item(OpStep, 4'd0, 2'd2, 4'd0);

    // --- Random phases, each under its own mask setting ---
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained(1'b1);
      case (p)
        0: begin
          write_mask(CfgInitial, 16'hFFFF);
          write_mask(CfgFinal, 16'h0000);
        end
        1: begin
          write_mask(CfgInitial, 16'h0000);
          write_mask(CfgFinal, 16'hFFFF);
        end
        2: begin
          write_mask(CfgInitial, 16'h8000);
          write_mask(CfgFinal, 16'h0001);
        end
        default: begin
          write_mask(CfgInitial, ($urandom_range(0, 3) == 0) ? 16'($urandom) : sparse_mask());
          write_mask(CfgFinal, ($urandom_range(0, 1) == 0) ? 16'($urandom) : sparse_mask());
        end
      endcase
      tx_no_gaps   = (p % 4 == 1);
      rx_no_stalls = (p % 3 == 2);
      run_phase(PhaseItems, PhaseAdds);
    end

    // --- Drain and report ---
    item_bus.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    leftover = sb.pending_results.size();
    if (leftover != 0) $display("%0d expected results never arrived", leftover);
    $display("coverage: %0d adds, %0d starts, %0d steps, %0d unused ops, %0d mask writes",
             sb.op_counts[OpAdd], sb.op_counts[OpStart], sb.op_counts[OpStep],
             sb.op_counts[OpUnused], cfg_writes);
    $display("checked %0d results (%0d empty, %0d holding a final state), %0d mismatches",
             sb.results_checked, sb.empty_results, sb.final_results, sb.mismatches);
    if (sb.mismatches == 0 && leftover == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
